### rtl/bole_pkg.sv
package bole_pkg;

    // Default list capacity
    localparam int DEF_CAPACITY = 16;

    // Field widths fixed by the interface
    localparam int ID_W     = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_SORTED = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_HEAD   = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_ID     = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_TAIL   = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Position selector shared by inserts and removals
    localparam logic [1:0] MODE_HEAD  = 2'd0;
    localparam logic [1:0] MODE_MATCH = 2'd1;  // sorted place or id match
    localparam logic [1:0] MODE_TAIL  = 2'd2;

    // Token that walks down the cell chain, one cell per cycle
    typedef struct packed {
        logic            valid;
        logic            act;    // request not refused as full or empty
        logic            ins;    // 1 insert, 0 remove
        logic [1:0]      mode;
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] carry;  // entry displaced by an insert
        logic            hit;    // position already found upstream
    } pass_t;

endpackage

### rtl/bole_cell.sv
module bole_cell #(
    parameter int CAPACITY = 16,
    parameter int IDX      = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bole_pkg::pass_t      pass_in,
    input  logic [$clog2(CAPACITY+1)-1:0] count,
    input  logic [bole_pkg::ID_W-1:0]     nbr,
    output logic [bole_pkg::ID_W-1:0]     entry,
    output bole_pkg::pass_t      pass_out
);
    import bole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX1_C = CNT_W'(IDX + 1);

    logic [ID_W-1:0] entry_reg;
    logic [ID_W-1:0] entry_next;
    pass_t           pass_reg;
    pass_t           pass_next;

    logic place;
    logic match;
    logic less;

    assign less = $signed(entry_reg) < $signed(pass_in.key);

    // Insert position: cell 0 for head, first entry not less than the key for sorted, or the slot at the count
    assign place = !pass_in.hit &&
                   ((count == IDX_C) ||
                    (pass_in.mode == MODE_HEAD) ||
                    ((pass_in.mode == MODE_MATCH) && !less));

    // Removal position
    assign match = (pass_in.mode == MODE_HEAD) ||
                   ((pass_in.mode == MODE_MATCH) && (entry_reg == pass_in.key)) ||
                   ((pass_in.mode == MODE_TAIL) && (count == IDX1_C));

    // Cell update: insert shifts up through carry, remove pulls from the neighbor
    always_comb
    begin
        entry_next = entry_reg;
        pass_next  = pass_in;
        if (pass_in.valid && pass_in.act) begin
            if (pass_in.ins) begin
                if (IDX_C <= count) begin
                    if (place) begin
                        entry_next      = pass_in.key;
                        pass_next.carry = entry_reg;
                        pass_next.hit   = 1'b1;
                    end else if (pass_in.hit) begin
                        entry_next      = pass_in.carry;
                        pass_next.carry = entry_reg;
                    end
                end
            end else begin
                if ((IDX_C < count) && (pass_in.hit || match)) begin
                    entry_next    = nbr;
                    pass_next.hit = 1'b1;
                end
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pass_reg <= '0;
        end else begin
            pass_reg <= pass_next;
        end
    end

    assign entry    = entry_reg;
    assign pass_out = pass_reg;

endmodule

### rtl/bounded_ordered_list_engine.sv
// Bounded ordered list of signed 32-bit ids held in a row of CAPACITY cells, one entry
// per cell, with six operations: insert at head, sorted insert, insert at tail, remove at
// head, remove first matching id, remove at tail. A request is a token that walks the cell
// chain one cell per clock; each cell compares and shifts its own entry as the token
// passes. Every request, refused ones included, goes from acceptance to its result in the
// output register through the launch stage, which loads at acceptance, then CAPACITY cell
// stages, the result stage and the output stage; the move into the output register waits
// while a result held there is stalled. A new request is taken the clock after the
// previous result has moved into the output register, so requests never overlap. The
// output register decouples the sides: a request is accepted while an earlier result still
// waits there. Entry contents need no reset; only entries below the count are read.
module bounded_ordered_list_engine #(
    parameter int CAPACITY = bole_pkg::DEF_CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bole_pkg::OP_W-1:0]        operation,
    input  logic signed [bole_pkg::ID_W-1:0] key_id,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bole_pkg::STATUS_W-1:0]    status,
    output logic [bole_pkg::COUNT_W-1:0]     entry_count,
    output logic                             is_full,
    output logic                             is_empty
);
    import bole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                busy_reg;
    logic                busy_next;
    pass_t               launch_reg;
    pass_t               launch_next;
    logic [STATUS_W-1:0] pre_status_reg;
    logic [STATUS_W-1:0] pre_status_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [STATUS_W-1:0] out_status_next;
    logic [CNT_W-1:0]    out_count_reg;
    logic [CNT_W-1:0]    out_count_next;

    logic [ID_W-1:0] entries [CAPACITY];
    pass_t           passes  [CAPACITY];
    pass_t           last;
    logic            accept;
    logic            op_ins;
    logic            op_rem;
    logic            full;
    logic            empty;
    logic            out_free;
    logic            not_found;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    assign accept   = in_valid && !busy_reg;
    assign in_stall = busy_reg;
    assign op_ins   = (operation == OP_INS_HEAD) || (operation == OP_INS_SORTED) ||
                      (operation == OP_INS_TAIL);
    assign op_rem   = (operation == OP_REM_HEAD) || (operation == OP_REM_ID) ||
                      (operation == OP_REM_TAIL);
    assign full     = (count_reg == CAP_C);
    assign empty    = (count_reg == '0);
    assign out_free = !out_valid_reg || !out_stall;
    assign last     = passes[CAPACITY-1];

    // Cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ID_W-1:0] nbr_k;
        pass_t           in_k;

        if (k == CAPACITY - 1) begin : g_end
            assign nbr_k = '0;
        end else begin : g_mid
            assign nbr_k = entries[k+1];
        end

        if (k == 0) begin : g_first
            assign in_k = launch_reg;
        end else begin : g_next
            assign in_k = passes[k-1];
        end

        bole_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .pass_in  (in_k),
            .count    (count_reg),
            .nbr      (nbr_k),
            .entry    (entries[k]),
            .pass_out (passes[k])
        );
    end

    assign not_found = last.act && !last.ins && (last.mode == MODE_MATCH) && !last.hit;

    // Request launch, completion and output staging
    always_comb
    begin
        launch_next     = launch_reg;
        pre_status_next = pre_status_reg;
        busy_next       = busy_reg;
        count_next      = count_reg;
        res_valid_next  = res_valid_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        launch_next.valid = 1'b0;
        if (accept) begin
            busy_next         = 1'b1;
            launch_next.valid = 1'b1;
            launch_next.ins   = op_ins;
            launch_next.act   = (op_ins && !full) || (op_rem && !empty);
            launch_next.key   = key_id;
            launch_next.carry = '0;
            launch_next.hit   = 1'b0;
            case (operation)
                OP_INS_HEAD, OP_REM_HEAD:  launch_next.mode = MODE_HEAD;
                OP_INS_TAIL, OP_REM_TAIL:  launch_next.mode = MODE_TAIL;
                default:                   launch_next.mode = MODE_MATCH;
            endcase
            if (op_ins && full) begin
                pre_status_next = ST_FULL;
            end else if (op_rem && empty) begin
                pre_status_next = ST_EMPTY;
            end else begin
                pre_status_next = ST_DONE;
            end
        end

        // Token leaves the last cell: settle status and count
        if (last.valid) begin
            res_valid_next = 1'b1;
            if (!last.act) begin
                res_status_next = pre_status_reg;
            end else if (not_found) begin
                res_status_next = ST_NOT_FOUND;
            end else begin
                res_status_next = ST_DONE;
                if (last.ins) begin
                    count_next = count_reg + 1'b1;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
        end

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
        if (res_valid_reg && out_free) begin
            res_valid_next  = 1'b0;
            busy_next       = 1'b0;
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_count_next  = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg        <= '0;
            busy_reg         <= 1'b0;
            launch_reg       <= '0;
            res_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            count_reg        <= count_next;
            busy_reg         <= busy_next;
            launch_reg       <= launch_next;
            res_valid_reg    <= res_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_status_reg   <= pre_status_next;
        res_status_reg   <= res_status_next;
        out_status_reg   <= out_status_next;
        out_count_reg    <= out_count_next;
    end

    // Result ports
    assign count_ext   = {{COUNT_W{1'b0}}, out_count_reg};
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_count = count_ext[COUNT_W-1:0];
    assign is_full     = (out_count_reg == CAP_C);
    assign is_empty    = (out_count_reg == '0);

endmodule
